/* design/dirty_rectangle_coalescer_assert.svh */
// ---------------------------------------------------------------------------
// dirty_rectangle_coalescer_assert.svh
// assertion macros shared by the coalescer checker
// ---------------------------------------------------------------------------
`ifndef DIRTY_RECTANGLE_COALESCER_ASSERT_SVH
`define DIRTY_RECTANGLE_COALESCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/drc_pkg.sv */
// ---------------------------------------------------------------------------
// drc_pkg
// types and constants of the dirty rectangle coalescer
// ---------------------------------------------------------------------------
package drc_pkg;

   // field widths
   localparam int X_W        = 12;
   localparam int Y_W        = 12;
   localparam int W_W        = 13;
   localparam int H_W        = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_RES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL   = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] X_RES_RST = 13'd1024;
   localparam logic [CSR_DATA_W-1:0] Y_RES_RST = 13'd768;
   localparam logic [CSR_DATA_W-1:0] TOL_RST   = 13'd40;

   // item commands
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic [W_W-1:0] w;
      logic [H_W-1:0] h;
   } rect_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_MERGE,
      ST_APPEND,
      ST_FL_READ,
      ST_FL_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic idx_clear;
      logic rd_en;
      logic mem_merge;
      logic mem_append;
      logic count_clear;
      logic out_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_flush;
      logic add_ok;
      logic hit;
      logic scan_more;
      logic rd_vld;
      logic full;
      logic out_free;
      logic flush_last;
   } sts_type;

endpackage

/* design/drc_if.sv */
// ---------------------------------------------------------------------------
// drc_if
// request and response channels of the dirty rectangle coalescer
// ---------------------------------------------------------------------------
interface drc_req_if;
   import drc_pkg::*;

   logic           valid;
   logic           ready;
   logic           cmd;
   logic [X_W-1:0] rect_x;
   logic [Y_W-1:0] rect_y;
   logic [W_W-1:0] rect_width;
   logic [H_W-1:0] rect_height;

   modport source (output valid, cmd, rect_x, rect_y, rect_width, rect_height,
                   input ready);
   modport sink (input valid, cmd, rect_x, rect_y, rect_width, rect_height,
                 output ready);
   modport monitor (input valid, ready, cmd, rect_x, rect_y, rect_width,
                    rect_height);
endinterface

interface drc_rsp_if;
   import drc_pkg::*;

   logic           valid;
   logic           ready;
   logic [X_W-1:0] out_x;
   logic [Y_W-1:0] out_y;
   logic [W_W-1:0] out_width;
   logic [H_W-1:0] out_height;
   logic           last;

   modport source (output valid, out_x, out_y, out_width, out_height, last,
                   input ready);
   modport sink (input valid, out_x, out_y, out_width, out_height, last,
                 output ready);
   modport monitor (input valid, ready, out_x, out_y, out_width, out_height,
                    last);
endinterface

/* design/drc_datapath.sv */
// ---------------------------------------------------------------------------
// drc_datapath
// rectangle table, scan compare, merge, counters and response register
// ---------------------------------------------------------------------------
module drc_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drc_pkg::ctl_type                    ctl,
   output drc_pkg::sts_type                    sts,
   input  logic                                in_cmd,
   input  drc_pkg::rect_type                   in_rect,
   input  logic                                csr_wr_en,
   input  logic [drc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output drc_pkg::rect_type                   rsp_rect,
   output logic                                rsp_last
);
   import drc_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W = W_W + 1;

   function automatic logic [W_W-1:0] absdiff(input logic [W_W-1:0] a,
                                              input logic [W_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic                  cmd_ff;
   rect_type              item_ff;
   logic [CSR_DATA_W-1:0] xres_ff;
   logic [CSR_DATA_W-1:0] yres_ff;
   logic [CSR_DATA_W-1:0] tol_ff;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         count_ff;
   logic                  rd_vld_ff;
   logic [AW-1:0]         rd_idx_ff;
   rect_type              rd_data_ff;
   rect_type              table_ff [TABLE_DEPTH];
   logic                  rsp_valid_ff;
   rect_type              rsp_rect_ff;
   logic                  rsp_last_ff;

   logic [SUM_W-1:0] item_right;
   logic [SUM_W-1:0] item_bottom;
   logic [SUM_W-1:0] ent_right;
   logic [SUM_W-1:0] ent_bottom;
   logic [SUM_W-1:0] max_right;
   logic [SUM_W-1:0] max_bottom;
   logic [X_W-1:0]   min_x;
   logic [Y_W-1:0]   min_y;
   rect_type         merged;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   rect_type         wr_data;
   logic             out_free;

   // captured item
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= in_cmd;
         item_ff <= in_rect;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xres_ff <= X_RES_RST;
         yres_ff <= Y_RES_RST;
         tol_ff  <= TOL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_RES: xres_ff <= csr_wdata;
            CSR_Y_RES: yres_ff <= csr_wdata;
            CSR_TOL:   tol_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // bounds check of the captured rectangle
   assign item_right  = SUM_W'(item_ff.x) + SUM_W'(item_ff.w);
   assign item_bottom = SUM_W'(item_ff.y) + SUM_W'(item_ff.h);

   // bounding box of the read entry and the captured rectangle
   assign ent_right  = SUM_W'(rd_data_ff.x) + SUM_W'(rd_data_ff.w);
   assign ent_bottom = SUM_W'(rd_data_ff.y) + SUM_W'(rd_data_ff.h);
   assign max_right  = (item_right > ent_right) ? item_right : ent_right;
   assign max_bottom = (item_bottom > ent_bottom) ? item_bottom : ent_bottom;
   assign min_x      = (item_ff.x < rd_data_ff.x) ? item_ff.x : rd_data_ff.x;
   assign min_y      = (item_ff.y < rd_data_ff.y) ? item_ff.y : rd_data_ff.y;

   always_comb begin
      merged.x = min_x;
      merged.y = min_y;
      merged.w = W_W'(max_right - SUM_W'(min_x));
      merged.h = H_W'(max_bottom - SUM_W'(min_y));
   end

   // table write port
   assign wr_en   = ctl.mem_merge | ctl.mem_append;
   assign wr_addr = ctl.mem_merge ? rd_idx_ff : count_ff[AW-1:0];
   assign wr_data = ctl.mem_merge ? merged : item_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
   end

   // table read port with registered data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= table_ff[idx_ff[AW-1:0]];
         rd_idx_ff  <= idx_ff[AW-1:0];
      end
   end

   // read pointer and read-data valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctl.rd_en;
         if (ctl.idx_clear) begin
            idx_ff <= '0;
         end else if (ctl.rd_en) begin
            idx_ff <= idx_ff + CW'(1);
         end
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.count_clear) begin
         count_ff <= '0;
      end else if (ctl.mem_append) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_rect_ff <= rd_data_ff;
         rsp_last_ff <= sts.flush_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rect  = rsp_rect_ff;
   assign rsp_last  = rsp_last_ff;

   // status to the controller
   always_comb begin
      sts.is_flush   = (cmd_ff == CMD_FLUSH);
      sts.add_ok     = (item_ff.w != '0) && (item_ff.h != '0) &&
                       (W_W'(item_ff.x) < xres_ff) && (H_W'(item_ff.y) < yres_ff) &&
                       (item_right <= SUM_W'(xres_ff)) &&
                       (item_bottom <= SUM_W'(yres_ff));
      sts.hit        = rd_vld_ff &&
                       (absdiff(W_W'(rd_data_ff.x), W_W'(item_ff.x)) < tol_ff) &&
                       (absdiff(W_W'(rd_data_ff.y), W_W'(item_ff.y)) < tol_ff) &&
                       (absdiff(rd_data_ff.w, item_ff.w) < tol_ff) &&
                       (absdiff(rd_data_ff.h, item_ff.h) < tol_ff);
      sts.scan_more  = (idx_ff < count_ff);
      sts.rd_vld     = rd_vld_ff;
      sts.full       = (count_ff == CW'(TABLE_DEPTH));
      sts.out_free   = out_free;
      sts.flush_last = (idx_ff == count_ff);
   end

endmodule

/* design/drc_controller.sv */
// ---------------------------------------------------------------------------
// drc_controller
// sequencer for validate, scan, merge, append and flush of one item
// ---------------------------------------------------------------------------
module drc_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  drc_pkg::sts_type sts,
   output drc_pkg::ctl_type ctl
);
   import drc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.is_flush)    state_in = ST_FL_READ;
            else if (sts.add_ok) state_in = ST_SCAN;
            else                 state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.hit) begin
               state_in = ST_MERGE;
            end else if (!sts.scan_more && !sts.rd_vld) begin
               state_in = ST_APPEND;
            end
         end
         ST_MERGE: begin
            state_in = ST_IDLE;
         end
         ST_APPEND: begin
            state_in = sts.full ? ST_FL_READ : ST_IDLE;
         end
         ST_FL_READ: begin
            if (sts.scan_more)    state_in = ST_FL_OUT;
            else if (sts.is_flush) state_in = ST_IDLE;
            else                  state_in = ST_APPEND;
         end
         ST_FL_OUT: begin
            if (sts.out_free) begin
               if (!sts.flush_last)   state_in = ST_FL_READ;
               else if (sts.is_flush) state_in = ST_IDLE;
               else                   state_in = ST_APPEND;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            ctl.capture   = req_valid;
            ctl.idx_clear = 1'b1;
         end
         ST_SCAN: begin
            ctl.rd_en = sts.scan_more && !sts.hit;
         end
         ST_MERGE: begin
            ctl.mem_merge = 1'b1;
         end
         ST_APPEND: begin
            // a full table is flushed before the append
            ctl.idx_clear  = sts.full;
            ctl.mem_append = !sts.full;
         end
         ST_FL_READ: begin
            ctl.rd_en       = sts.scan_more;
            ctl.count_clear = !sts.scan_more;
         end
         ST_FL_OUT: begin
            ctl.out_load    = sts.out_free;
            ctl.count_clear = sts.out_free && sts.flush_last;
         end
         default: ;
      endcase
   end

endmodule

/* design/dirty_rectangle_coalescer.sv */
// ---------------------------------------------------------------------------
// dirty_rectangle_coalescer
// gathers screen update rectangles into a table, merges near matches and
// emits the stored list on flush
// ---------------------------------------------------------------------------
// channel   dir   handshake      payload
// req       in    valid/ready    cmd, rect_x, rect_y, rect_width, rect_height
// rsp       out   valid/ready    out_x, out_y, out_width, out_height, last
// csr       in    csr_wr_en      csr_index, csr_wdata
//
// one item at a time; the table is a single-port-write, single-read memory
// add: the captured item is checked, then compared with each stored entry in turn
// add merging into entry k ends the scan at k; a full-table append adds a flush
// flush: each entry is read, then loaded into rsp, before the next read; empty emits none
// reset is synchronous; the table itself is not cleared, the count is
// a stalled rsp holds the flush sequence; req may be taken while rsp waits
// ---------------------------------------------------------------------------
module dirty_rectangle_coalescer #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   drc_req_if.sink                        req,
   drc_rsp_if.source                      rsp,
   input  logic                           csr_wr_en,
   input  logic [drc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import drc_pkg::*;

   ctl_type  ctl;
   sts_type  sts;
   rect_type in_rect;
   rect_type rsp_rect;
   logic     req_ready;

   // request payload into a rectangle
   always_comb begin
      in_rect.x = req.rect_x;
      in_rect.y = req.rect_y;
      in_rect.w = req.rect_width;
      in_rect.h = req.rect_height;
   end

   assign req.ready = req_ready;

   drc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   drc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .in_cmd    (req.cmd),
      .in_rect   (in_rect),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_rect  (rsp_rect),
      .rsp_last  (rsp.last)
   );

   // response payload
   assign rsp.out_x      = rsp_rect.x;
   assign rsp.out_y      = rsp_rect.y;
   assign rsp.out_width  = rsp_rect.w;
   assign rsp.out_height = rsp_rect.h;

endmodule

/* design/drc_checker.sv */
// ---------------------------------------------------------------------------
// drc_checker
// port-level checks of the coalescer, bound to the top level
// ---------------------------------------------------------------------------
`include "dirty_rectangle_coalescer_assert.svh"

module drc_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [drc_pkg::X_W-1:0]  rsp_out_x,
   input logic [drc_pkg::Y_W-1:0]  rsp_out_y,
   input logic [drc_pkg::W_W-1:0]  rsp_out_width,
   input logic [drc_pkg::H_W-1:0]  rsp_out_height,
   input logic                     rsp_last
);
   import drc_pkg::*;

   logic [X_W+Y_W+W_W+H_W:0] rsp_payload;

   // whole response item as one vector
   assign rsp_payload = {rsp_out_x, rsp_out_y, rsp_out_width, rsp_out_height, rsp_last};

   // a stalled item keeps its rectangle
   `DRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp item changed while stalled")

   // an accepted item takes the block out of idle, which drops req ready
   `DRC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "req ready right after accept")

   // no rectangle can come out the cycle after an item is taken
   `DRC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "rsp raised right after accept")

   // a flush run is not over while a non-final rectangle waits
   `DRC_ASSERT_SAME(a_run_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "req ready in the middle of a flush run")

endmodule

bind dirty_rectangle_coalescer drc_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_out_x      (rsp.out_x),
   .rsp_out_y      (rsp.out_y),
   .rsp_out_width  (rsp.out_width),
   .rsp_out_height (rsp.out_height),
   .rsp_last       (rsp.last)
);

/* test/dirty_rectangle_coalescer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dirty_rectangle_coalescer_tb
// drives add and flush items into the coalescer and predicts every emitted
// rectangle with a behavioral copy of the table; each result is compared
// field by field against the oldest prediction, over several register
// settings including the resolution and tolerance extremes
// ---------------------------------------------------------------------------
module dirty_rectangle_coalescer_tb;
   import drc_pkg::*;

   localparam int DEPTH     = 32;
   localparam int DRAIN_CYC = 200;   // longest add scan plus a full-table flush, with margin
   localparam int WATCHDOG  = 4000;
   localparam int IDLE_PCT  = 21;

   typedef struct packed {
      rect_type rect;
      logic     last;
   } dirty_rect_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   drc_req_if req_if ();
   drc_rsp_if rsp_if ();

   dirty_rectangle_coalescer #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted table and registers
   int tab_x [DEPTH];
   int tab_y [DEPTH];
   int tab_w [DEPTH];
   int tab_h [DEPTH];
   int tab_count = 0;
   int cfg_xres  = X_RES_RST;
   int cfg_yres  = Y_RES_RST;
   int cfg_tol   = TOL_RST;

   dirty_rect_type pending_rects [$];
   int             err_count    = 0;
   int             quiet_cycles = 0;
   bit             idle_on      = 1'b1;

   // clock
   always #4 clock = ~clock;

   function automatic int gap_of(input int a, input int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int fit(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   // emit every stored entry in order, last marked, then empty the table
   task automatic flush_table();
      dirty_rect_type r;
      for (int k = 0; k < tab_count; k++) begin
         r.rect.x = tab_x[k][X_W-1:0];
         r.rect.y = tab_y[k][Y_W-1:0];
         r.rect.w = tab_w[k][W_W-1:0];
         r.rect.h = tab_h[k][H_W-1:0];
         r.last   = (k == tab_count - 1);
         pending_rects.push_back(r);
      end
      tab_count = 0;
   endtask

   // validate, merge into the first near entry, or append
   task automatic add_rect(input int x, input int y, input int w, input int h);
      int nx, ny, right, bottom;
      if (w == 0 || h == 0 || x >= cfg_xres || y >= cfg_yres ||
          x + w > cfg_xres || y + h > cfg_yres)
         return;
      for (int k = 0; k < tab_count; k++) begin
         if (gap_of(tab_x[k], x) < cfg_tol && gap_of(tab_y[k], y) < cfg_tol &&
             gap_of(tab_w[k], w) < cfg_tol && gap_of(tab_h[k], h) < cfg_tol) begin
            nx     = (x < tab_x[k]) ? x : tab_x[k];
            ny     = (y < tab_y[k]) ? y : tab_y[k];
            right  = (x + w > tab_x[k] + tab_w[k]) ? x + w : tab_x[k] + tab_w[k];
            bottom = (y + h > tab_y[k] + tab_h[k]) ? y + h : tab_y[k] + tab_h[k];
            tab_x[k] = nx;
            tab_y[k] = ny;
            tab_w[k] = right - nx;
            tab_h[k] = bottom - ny;
            return;
         end
      end
      // full table goes out before the append
      if (tab_count >= DEPTH)
         flush_table();
      tab_x[tab_count] = x;
      tab_y[tab_count] = y;
      tab_w[tab_count] = w;
      tab_h[tab_count] = h;
      tab_count++;
   endtask

   // send one item, with a random gap before it when idling is on, and predict on acceptance
   task automatic send_item(input logic cmd, input int x, input int y, input int w,
                            input int h);
      x = x & 'hFFF;
      y = y & 'hFFF;
      w = w & 'h1FFF;
      h = h & 'h1FFF;
      if (idle_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.rect_x      <= x[X_W-1:0];
      req_if.rect_y      <= y[Y_W-1:0];
      req_if.rect_width  <= w[W_W-1:0];
      req_if.rect_height <= h[H_W-1:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (cmd == CMD_FLUSH)
         flush_table();
      else
         add_rect(x, y, w, h);
   endtask

   // stop sending, wait for every expected rectangle, then let the block settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic set_config(input int xr, input int yr, input int tol);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_X_RES;
      csr_wdata <= xr[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_Y_RES;
      csr_wdata <= yr[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_TOL;
      csr_wdata <= tol[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_xres = xr & 'h1FFF;
      cfg_yres = yr & 'h1FFF;
      cfg_tol  = tol & 'h1FFF;
   endtask

   // one random item: flush, noise, near an existing entry, or well-formed
   task automatic send_random(input int flush_pct);
      int pick, k, d, x, y, w, h;
      pick = $urandom_range(99);
      if (pick < flush_pct) begin
         send_item(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < flush_pct + 12) begin
         // any coordinate, widths and heights up to 4096, mostly dropped
         send_item(CMD_ADD, $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4096), $urandom_range(4096));
      end else if (pick < flush_pct + 50 && tab_count > 0) begin
         // around a stored entry so the tolerance edge gets hit
         k = $urandom_range(tab_count - 1);
         d = (cfg_tol < 1) ? 1 : ((cfg_tol > 64) ? 64 : cfg_tol);
         x = fit(tab_x[k] + int'($urandom_range(2 * d)) - d, 0, cfg_xres - 1);
         y = fit(tab_y[k] + int'($urandom_range(2 * d)) - d, 0, cfg_yres - 1);
         w = fit(tab_w[k] + int'($urandom_range(2 * d)) - d, 1, cfg_xres - x);
         h = fit(tab_h[k] + int'($urandom_range(2 * d)) - d, 1, cfg_yres - y);
         send_item(CMD_ADD, x, y, w, h);
      end else begin
         x = $urandom_range(cfg_xres - 1);
         y = $urandom_range(cfg_yres - 1);
         w = $urandom_range(1, cfg_xres - x);
         h = $urandom_range(1, cfg_yres - y);
         if ($urandom_range(1)) begin
            w = fit(w, 1, 48);
            h = fit(h, 1, 48);
         end
         send_item(CMD_ADD, x, y, w, h);
      end
   endtask

   // field extremes, every drop reason, merge and its strict bound, flushes
   task automatic test_directed_cases();
      send_item(CMD_ADD, 0, 0, 1, 1);
      send_item(CMD_ADD, 1023, 767, 1, 1);
      send_item(CMD_ADD, 0, 0, 1024, 768);
      send_item(CMD_ADD, 10, 0, 0, 5);
      send_item(CMD_ADD, 10, 0, 5, 0);
      send_item(CMD_ADD, 1024, 0, 1, 1);
      send_item(CMD_ADD, 0, 768, 1, 1);
      send_item(CMD_ADD, 1000, 0, 25, 1);
      send_item(CMD_ADD, 0, 760, 1, 9);
      send_item(CMD_ADD, 4095, 4095, 4096, 4096);
      send_item(CMD_ADD, 100, 100, 50, 60);
      send_item(CMD_ADD, 120, 90, 70, 40);
      // width differs by exactly the tolerance, so no merge
      send_item(CMD_ADD, 139, 100, 50, 60);
      send_item(CMD_FLUSH, 4095, 4095, 8191, 8191);
      // empty table flush
      send_item(CMD_FLUSH, 0, 0, 0, 0);
   endtask

   // zero tolerance, no idling: the table fills and flushes on append
   task automatic test_table_overflow();
      wait_drained();
      set_config(4096, 4096, 0);
      idle_on = 1'b0;
      for (int i = 0; i < 70; i++)
         send_random(0);
      send_item(CMD_FLUSH, 0, 0, 0, 0);
      wait_drained();
      idle_on = 1'b1;
   endtask

   // random traffic over a range of register settings
   task automatic test_random_traffic();
      int xr  [7] = '{640, 4096, 1, 4096, 1024, 300, 4096};
      int yr  [7] = '{480, 4096, 1, 4096, 768, 4096, 1};
      int tol [7] = '{30, 4096, 0, 200, 40, 1, 100};
      int cnt [7] = '{55, 55, 30, 60, 60, 55, 55};
      int fpc [7] = '{4, 8, 3, 5, 4, 6, 6};
      for (int p = 0; p < 7; p++) begin
         wait_drained();
         set_config(xr[p], yr[p], tol[p]);
         idle_on = (p != 4);
         for (int i = 0; i < cnt[p]; i++)
            send_random(fpc[p]);
      end
      idle_on = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [12:0] got,
                              input logic [12:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // compare each accepted rectangle with the oldest prediction
   always @(posedge clock) begin : rect_check
      dirty_rect_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rects.size() == 0) begin
            report_mismatch($sformatf("unexpected rect x=%0d y=%0d w=%0d h=%0d",
                                      rsp_if.out_x, rsp_if.out_y,
                                      rsp_if.out_width, rsp_if.out_height));
         end else begin
            want = pending_rects.pop_front();
            check_field("out_x", rsp_if.out_x, want.rect.x);
            check_field("out_y", rsp_if.out_y, want.rect.y);
            check_field("out_width", rsp_if.out_width, want.rect.w);
            check_field("out_height", rsp_if.out_height, want.rect.h);
            check_field("last", rsp_if.last, want.last);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // stall watchdog
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.cmd         <= CMD_ADD;
      req_if.rect_x      <= '0;
      req_if.rect_y      <= '0;
      req_if.rect_width  <= '0;
      req_if.rect_height <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_X_RES;
      csr_wdata          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_table_overflow();
      test_random_traffic();
      wait_drained();
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
